[hw/rtl/assert_macros.svh]
// assertion macros used by mrt_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, checked while out of reset
`define MRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define MRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/mrt_pkg.sv]
// shared types and constants of the markov regime tracker
// no dependencies
`timescale 1ns / 1ps

package mrt_pkg;

  localparam int unsigned QUOT_W        = 22;
  localparam int unsigned ITERATIONS    = 10;
  localparam int unsigned UPDATE_PERIOD = 10;
  localparam logic [16:0] ONE_Q16       = 17'd65536;

  localparam logic [1:0] REG_REGION_COUNT = 2'd0;
  localparam logic [1:0] REG_BIAS_STEP    = 2'd1;
  localparam logic [1:0] REG_MIN_SAMPLES  = 2'd2;

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_STEADY = 2'd1,
    FUNC_TRANS  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BIN_MUL,
    S_BIN_DIV,
    S_BIN_WAIT,
    S_INC_RD,
    S_INC_WR,
    S_RS_RD,
    S_RS_ACC,
    S_T_RD,
    S_T_DIV,
    S_T_WAIT,
    S_M_RD,
    S_M_MUL,
    S_M_ACC,
    S_N_DIV,
    S_N_WAIT,
    S_Q_RD,
    S_Q_DIV,
    S_Q_WAIT,
    S_CLR_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } mem_ctrl_t;

endpackage

[hw/rtl/mrt_divider.sv]
// shared restoring divider, one quotient bit per cycle
// depends on mrt_pkg
`timescale 1ns / 1ps

module mrt_divider import mrt_pkg::*; #(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 42
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  logic [DEN_W-1:0]  rem_q, rem_d, den_q, den_d;
  logic [QUOT_W-1:0] low_q, low_d, quot_q, quot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]    trial, diff;
  logic              ge;

  always_comb begin
    trial  = {rem_q, low_q[QUOT_W-1]};
    diff   = trial - {1'b0, den_q};
    ge     = trial >= {1'b0, den_q};
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i[NUM_W-1:QUOT_W];
      low_d  = num_i[QUOT_W-1:0];
      den_d  = den_i;
      cnt_d  = CNT_W'(QUOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_d  = {low_q[QUOT_W-2:0], 1'b0};
      quot_d = {quot_q[QUOT_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[hw/rtl/mrt_count_mem.sv]
// transition count memory with per-entry valid bits, registered read
// depends on mrt_pkg
`timescale 1ns / 1ps

module mrt_count_mem import mrt_pkg::*; #(
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mem_ctrl_t         ctrl_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic [DATA_W-1:0] rd_data_o
);

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl_i.clear) begin
      valid_q <= '0;
    end else if (ctrl_i.wr_en) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/mrt_ram.sv]
// simple dual-port ram for the normalised transition matrix
// no dependencies
`timescale 1ns / 1ps

module mrt_ram #(
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 17
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [2 ** ADDR_W];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/markov_regime_tracker.sv]
// markov regime tracker top: sequencer, shared multiplier and divider, state
// depends on mrt_pkg, mrt_divider, mrt_count_mem, mrt_ram
//
// channel   direction  signals
// s_axis    in         tdata {col_index, row_index, bias}, tuser func
// m_axis    out        tdata {value, record_count, change_count, prev, changed, regime}
// apb       in/out     region_count, bias_step, min_records
//
// one item at a time; s_axis_tready is high only while the sequencer is idle
// steady reads answer from the held shares; clears and transition reads use one divide
// every tenth record adds the steady-state pass, whose length is set by the
// single 22-step divider and the multiply-accumulate, which reads, multiplies and
// accumulates one matrix term at a time
// reset and clear zero the count memory valid bits at once; no clearing pass
// a stalled m_axis holds its transfer; the sequencer waits before writing a new one
`timescale 1ns / 1ps

module markov_regime_tracker import mrt_pkg::*; #(
  parameter int unsigned MAX_REGIMES = 8,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // bias[15:0], row_index[18:16], col_index[21:19]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // regime[2:0], changed[3], previous_regime[6:4],
                                      // change_count[38:7], record_count[70:39],
                                      // value[87:71]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W   = $clog2(MAX_REGIMES);
  localparam int unsigned NW      = $clog2(MAX_REGIMES + 1);
  localparam int unsigned ADDR_W  = 2 * IDX_W;
  localparam int unsigned SUM_W   = COUNT_WIDTH + IDX_W;
  localparam int unsigned PROD_W  = 34;
  localparam int unsigned ACC_W   = PROD_W + 2 * IDX_W;
  localparam int unsigned DEN_W   = (SUM_W > ACC_W) ? SUM_W : ACC_W;
  localparam int unsigned NUM_W   = DEN_W + QUOT_W;
  localparam int unsigned RESET_N = (MAX_REGIMES < 4) ? MAX_REGIMES : 4;
  localparam int unsigned RESET_SHARE = (65536 + RESET_N / 2) / RESET_N;

  state_e state_q, state_d;
  func_e  func_q, func_d;

  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, last_q, last_d, cur_q, cur_d, ns_q, ns_d;
  logic             last_valid_q, last_valid_d, refresh_q, refresh_d;
  logic [3:0]       it_q, it_d, phase_q, phase_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [ACC_W-1:0] acc_q [MAX_REGIMES];
  logic [ACC_W-1:0] acc_d [MAX_REGIMES];
  logic [ACC_W-1:0] total_q, total_d, acc_sum;
  logic [16:0]      share_q [MAX_REGIMES];
  logic [16:0]      share_d [MAX_REGIMES];
  logic [16:0]      res_q, res_d;
  logic [31:0]      changes_q, changes_d, records_q, records_d;
  logic [3:0]       region_q;
  logic [15:0]      step_q, min_q, step_eff;
  logic [15:0]      bias_q, bias_d;
  logic [2:0]       col_q, col_d;
  logic [PROD_W-1:0] prod_q;
  logic [16:0]      mul_a, mul_b;
  logic             out_valid_q, out_valid_d;
  logic [87:0]      out_data_q, out_data_d;

  logic [NW-1:0]    n_eff;
  logic [IDX_W-1:0] last_idx;
  logic signed [23:0] bin_num;
  logic             changed;
  logic             t_advance, n_advance;

  mem_ctrl_t         cnt_ctrl;
  logic [ADDR_W-1:0] cnt_rd_addr, cnt_wr_addr;
  logic [COUNT_WIDTH-1:0] cnt_wr_data, cnt_rdata;
  logic              t_wr_en, t_rd_en;
  logic [ADDR_W-1:0] t_rd_addr, t_wr_addr;
  logic [16:0]       t_wr_data, t_rdata;

  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [QUOT_W-1:0] div_quot;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= 4'd4;
      step_q   <= 16'd256;
      min_q    <= 16'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_REGION_COUNT: region_q <= pwdata[3:0];
        REG_BIAS_STEP:    step_q   <= pwdata[15:0];
        REG_MIN_SAMPLES:  min_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_REGION_COUNT: prdata = 32'(region_q);
      REG_BIAS_STEP:    prdata = 32'(step_q);
      REG_MIN_SAMPLES:  prdata = 32'(min_q);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (region_q == 4'd0) begin
      n_eff = NW'(1);
    end else if ({1'b0, region_q} > 5'(MAX_REGIMES)) begin
      n_eff = NW'(MAX_REGIMES);
    end else begin
      n_eff = NW'(region_q);
    end
  end

  assign last_idx = IDX_W'(n_eff - 1'b1);
  assign step_eff = (step_q == 16'd0) ? 16'd1 : step_q;

  // shared multiplier, registered
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign bin_num = {{7{bias_q[15]}}, bias_q, 1'b0} + 24'(prod_q);
  assign acc_sum = acc_q[j_q] + ACC_W'(prod_q);
  assign changed = (({1'b0, records_q} + 33'd1) >= {17'b0, min_q}) && last_valid_q &&
                   (ns_q != last_q);

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    i_d          = i_q;
    j_d          = j_q;
    last_d       = last_q;
    cur_d        = cur_q;
    ns_d         = ns_q;
    last_valid_d = last_valid_q;
    refresh_d    = refresh_q;
    it_d         = it_q;
    phase_d      = phase_q;
    sum_d        = sum_q;
    acc_d        = acc_q;
    total_d      = total_q;
    share_d      = share_q;
    res_d        = res_q;
    changes_d    = changes_q;
    records_d    = records_q;
    bias_d       = bias_q;
    col_d        = col_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    mul_a        = share_q[i_q];
    mul_b        = t_rdata;
    cnt_ctrl     = '0;
    cnt_rd_addr  = {i_q, j_q};
    cnt_wr_addr  = {last_q, ns_q};
    cnt_wr_data  = cnt_rdata + 1'b1;
    t_wr_en      = 1'b0;
    t_rd_en      = 1'b0;
    t_rd_addr    = {i_q, j_q};
    t_wr_addr    = {i_q, j_q};
    t_wr_data    = 17'd0;
    div_start    = 1'b0;
    div_num      = NUM_W'({cnt_rdata, 16'b0}) + NUM_W'(sum_q >> 1);
    div_den      = DEN_W'(sum_q);
    t_advance    = 1'b0;
    n_advance    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          func_d = func_e'(s_axis_tuser);
          bias_d = s_axis_tdata[15:0];
          col_d  = s_axis_tdata[21:19];
          case (func_e'(s_axis_tuser))
            FUNC_RECORD: state_d = S_BIN_MUL;
            FUNC_STEADY: begin
              res_d   = ({2'b0, s_axis_tdata[18:16]} < 5'(n_eff)) ?
                        share_q[IDX_W'(s_axis_tdata[18:16])] : 17'd0;
              state_d = S_OUT;
            end
            FUNC_TRANS: begin
              if (({2'b0, s_axis_tdata[18:16]} < 5'(n_eff)) &&
                  ({2'b0, s_axis_tdata[21:19]} < 5'(n_eff))) begin
                i_d       = IDX_W'(s_axis_tdata[18:16]);
                j_d       = '0;
                sum_d     = '0;
                refresh_d = 1'b0;
                state_d   = S_RS_RD;
              end else begin
                res_d   = 17'd0;
                state_d = S_OUT;
              end
            end
            default: begin
              div_start = 1'b1;
              div_num   = NUM_W'(ONE_Q16) + NUM_W'(n_eff >> 1);
              div_den   = DEN_W'(n_eff);
              state_d   = S_CLR_WAIT;
            end
          endcase
        end
      end
      S_BIN_MUL: begin
        mul_a   = 17'(n_eff);
        mul_b   = {1'b0, step_eff};
        state_d = S_BIN_DIV;
      end
      S_BIN_DIV: begin
        if (bin_num[23]) begin
          ns_d    = '0;
          state_d = S_INC_RD;
        end else begin
          div_start = 1'b1;
          div_num   = NUM_W'(bin_num[22:0]);
          div_den   = DEN_W'({step_eff, 1'b0});
          state_d   = S_BIN_WAIT;
        end
      end
      S_BIN_WAIT: begin
        if (div_done) begin
          ns_d    = (div_quot >= QUOT_W'(n_eff)) ? last_idx : IDX_W'(div_quot);
          state_d = S_INC_RD;
        end
      end
      S_INC_RD: begin
        if (last_valid_q) begin
          cnt_ctrl.rd_en = 1'b1;
          cnt_rd_addr    = {last_q, ns_q};
          state_d        = S_INC_WR;
        end else begin
          state_d = S_OUT;
        end
      end
      S_INC_WR: begin
        cnt_ctrl.wr_en = (cnt_rdata != '1);
        if (phase_q == 4'd0) begin
          i_d       = '0;
          j_d       = '0;
          sum_d     = '0;
          refresh_d = 1'b1;
          state_d   = S_RS_RD;
        end else begin
          state_d = S_OUT;
        end
      end
      S_RS_RD: begin
        cnt_ctrl.rd_en = 1'b1;
        state_d        = S_RS_ACC;
      end
      S_RS_ACC: begin
        sum_d = sum_q + SUM_W'(cnt_rdata);
        if (j_q == last_idx) begin
          j_d     = '0;
          state_d = refresh_q ? S_T_RD : S_Q_RD;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_RS_RD;
        end
      end
      S_T_RD: begin
        cnt_ctrl.rd_en = 1'b1;
        state_d        = S_T_DIV;
      end
      S_T_DIV: begin
        if (sum_q == '0) begin
          t_wr_en   = 1'b1;
          t_wr_data = (i_q == j_q) ? ONE_Q16 : 17'd0;
          t_advance = 1'b1;
        end else begin
          div_start = 1'b1;
          state_d   = S_T_WAIT;
        end
      end
      S_T_WAIT: begin
        if (div_done) begin
          t_wr_en   = 1'b1;
          t_wr_data = 17'(div_quot);
          t_advance = 1'b1;
        end
      end
      S_M_RD: begin
        t_rd_en = 1'b1;
        state_d = S_M_MUL;
      end
      S_M_MUL: begin
        state_d = S_M_ACC;
      end
      S_M_ACC: begin
        acc_d[j_q] = acc_sum;
        if (i_q == last_idx) begin
          i_d     = '0;
          total_d = total_q + acc_sum;
          if (j_q == last_idx) begin
            j_d     = '0;
            state_d = S_N_DIV;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_M_RD;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_M_RD;
        end
      end
      S_N_DIV: begin
        if (total_q == '0) begin
          share_d[j_q] = 17'd0;
          n_advance    = 1'b1;
        end else begin
          div_start = 1'b1;
          div_num   = NUM_W'({acc_q[j_q], 16'b0}) + NUM_W'(total_q >> 1);
          div_den   = DEN_W'(total_q);
          state_d   = S_N_WAIT;
        end
      end
      S_N_WAIT: begin
        if (div_done) begin
          share_d[j_q] = 17'(div_quot);
          n_advance    = 1'b1;
        end
      end
      S_Q_RD: begin
        cnt_ctrl.rd_en = 1'b1;
        cnt_rd_addr    = {i_q, IDX_W'(col_q)};
        state_d        = S_Q_DIV;
      end
      S_Q_DIV: begin
        if (sum_q == '0) begin
          res_d   = 17'd0;
          state_d = S_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = S_Q_WAIT;
        end
      end
      S_Q_WAIT: begin
        if (div_done) begin
          res_d   = 17'(div_quot);
          state_d = S_OUT;
        end
      end
      S_CLR_WAIT: begin
        if (div_done) begin
          res_d   = 17'(div_quot);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          case (func_q)
            FUNC_RECORD: begin
              if (changed && (changes_q != '1)) begin
                changes_d = changes_q + 1'b1;
              end
              if (records_q != '1) begin
                records_d = records_q + 1'b1;
                phase_d   = (phase_q == 4'(UPDATE_PERIOD - 1)) ? 4'd0 : phase_q + 1'b1;
              end
              last_d       = ns_q;
              cur_d        = ns_q;
              last_valid_d = 1'b1;
              out_data_d   = {17'd0, records_d, changes_d,
                              changed ? 3'(last_q) : 3'd0, changed, 3'(ns_q)};
            end
            FUNC_CLEAR: begin
              cnt_ctrl.clear = 1'b1;
              last_d         = '0;
              cur_d          = '0;
              last_valid_d   = 1'b0;
              changes_d      = '0;
              records_d      = '0;
              phase_d        = '0;
              for (int k = 0; k < int'(MAX_REGIMES); k++) begin
                share_d[k] = res_q;
              end
              out_data_d = '0;
            end
            default: begin
              out_data_d = {res_q, records_q, changes_q, 3'd0, 1'b0, 3'(cur_q)};
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase

    // normalised matrix build: step to the next entry, then the next row, then the power iteration
    if (t_advance) begin
      if (j_q == last_idx) begin
        j_d   = '0;
        sum_d = '0;
        if (i_q == last_idx) begin
          i_d     = '0;
          it_d    = '0;
          total_d = '0;
          for (int k = 0; k < int'(MAX_REGIMES); k++) begin
            acc_d[k] = '0;
          end
          state_d = S_M_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_RS_RD;
        end
      end else begin
        j_d     = j_q + 1'b1;
        state_d = S_T_RD;
      end
    end

    // renormalisation: next share, then the next power iteration or, after the last, the output
    if (n_advance) begin
      if (j_q == last_idx) begin
        j_d = '0;
        if (it_q == 4'(ITERATIONS - 1)) begin
          state_d = S_OUT;
        end else begin
          it_d    = it_q + 1'b1;
          i_d     = '0;
          total_d = '0;
          for (int k = 0; k < int'(MAX_REGIMES); k++) begin
            acc_d[k] = '0;
          end
          state_d = S_M_RD;
        end
      end else begin
        j_d     = j_q + 1'b1;
        state_d = S_N_DIV;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      func_q       <= FUNC_RECORD;
      i_q          <= '0;
      j_q          <= '0;
      it_q         <= '0;
      refresh_q    <= 1'b0;
      last_q       <= '0;
      cur_q        <= '0;
      last_valid_q <= 1'b0;
      phase_q      <= '0;
      changes_q    <= '0;
      records_q    <= '0;
      out_valid_q  <= 1'b0;
      for (int k = 0; k < int'(MAX_REGIMES); k++) begin
        share_q[k] <= 17'(RESET_SHARE);
      end
    end else begin
      state_q      <= state_d;
      func_q       <= func_d;
      i_q          <= i_d;
      j_q          <= j_d;
      it_q         <= it_d;
      refresh_q    <= refresh_d;
      last_q       <= last_d;
      cur_q        <= cur_d;
      last_valid_q <= last_valid_d;
      phase_q      <= phase_d;
      changes_q    <= changes_d;
      records_q    <= records_d;
      out_valid_q  <= out_valid_d;
      share_q      <= share_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ns_q       <= ns_d;
    sum_q      <= sum_d;
    acc_q      <= acc_d;
    total_q    <= total_d;
    res_q      <= res_d;
    bias_q     <= bias_d;
    col_q      <= col_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  mrt_count_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (COUNT_WIDTH)
  ) u_count_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (cnt_ctrl),
    .rd_addr_i (cnt_rd_addr),
    .wr_addr_i (cnt_wr_addr),
    .wr_data_i (cnt_wr_data),
    .rd_data_o (cnt_rdata)
  );

  mrt_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (17)
  ) u_prob_ram (
    .clk_i     (clk_i),
    .wr_en_i   (t_wr_en),
    .wr_addr_i (t_wr_addr),
    .wr_data_i (t_wr_data),
    .rd_en_i   (t_rd_en),
    .rd_addr_i (t_rd_addr),
    .rd_data_o (t_rdata)
  );

  mrt_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

endmodule

[hw/rtl/mrt_checker.sv]
// port-level checks of the markov regime tracker, bound to the top level
// depends on assert_macros.svh and markov_regime_tracker
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mrt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);

  // one item in flight: an input transfer drops ready
  `MRT_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a stalled result holds
  `MRT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // a new result only appears while the sequencer is busy
  `MRT_ASSERT_NOW(a_out_from_work, clk_i, rst_ni, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind markov_regime_tracker mrt_checker u_mrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
